/* sv/hrck_pkg.sv */
// types, constants and key lookup tables shared by the hid report to console keys block
// depends on nothing
`default_nettype none
package hrck_pkg;

  localparam int KEY_SLOTS  = 6;
  localparam int LANES      = 2 * KEY_SLOTS;
  localparam int LANE_W     = $clog2(LANES);
  localparam int TAIL       = 4;
  localparam int NPEND      = LANES + TAIL;
  localparam int PICK_W     = $clog2(NPEND);
  localparam int MAX_EVENTS = 16;
  localparam int CNT_W      = $clog2(MAX_EVENTS);

  localparam logic [2:0] PLAT_C64   = 3'd0;
  localparam logic [2:0] PLAT_MSX   = 3'd1;
  localparam logic [2:0] PLAT_NES   = 3'd2;
  localparam logic [2:0] PLAT_ATARI = 3'd3;
  localparam logic [2:0] PLAT_SMS   = 3'd4;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_PAD  = 1'b1;

  localparam logic CFG_PLATFORM = 1'b0;
  localparam logic CFG_JOYSTICK = 1'b1;

  localparam logic [7:0] K_ENTER   = 8'h28;
  localparam logic [7:0] K_ESC     = 8'h29;
  localparam logic [7:0] K_BKSP    = 8'h2A;
  localparam logic [7:0] K_TAB     = 8'h2B;
  localparam logic [7:0] K_SPACE   = 8'h2C;
  localparam logic [7:0] K_X       = 8'h1B;
  localparam logic [7:0] K_Z       = 8'h1D;
  localparam logic [7:0] K_DEL     = 8'h4C;
  localparam logic [7:0] K_RIGHT   = 8'h4F;
  localparam logic [7:0] K_LEFT    = 8'h50;
  localparam logic [7:0] K_DOWN    = 8'h51;
  localparam logic [7:0] K_UP      = 8'h52;
  localparam logic [7:0] K_KPENTER = 8'h58;
  localparam logic [7:0] NOPOS     = 8'hFF;

  // positions are row * 8 + col
  localparam logic [7:0] C64_LETTERS [26] = '{
    8'd17, 8'd35, 8'd34, 8'd18, 8'd49, 8'd42, 8'd19, 8'd43,
    8'd12, 8'd20, 8'd44, 8'd21, 8'd36, 8'd60, 8'd52, 8'd13,
    8'd55, 8'd10, 8'd41, 8'd50, 8'd51, 8'd59, 8'd9,  8'd58,
    8'd11, 8'd33};
  localparam logic [7:0] C64_DIGITS [10] = '{
    8'd7, 8'd31, 8'd1, 8'd25, 8'd2, 8'd26, 8'd3, 8'd27, 8'd4, 8'd28};

  typedef struct packed {
    logic [7:0] modifier_byte;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_req_t;

  typedef struct packed {
    logic       event_kind;
    logic [3:0] matrix_row;
    logic [2:0] matrix_col;
    logic       pressed;
    logic [7:0] pad_byte;
    logic       last_event;
  } out_res_t;

  // per-report values for the events after the key events
  typedef struct packed {
    logic       shift;
    logic       ctrl;
    logic       alt;
    logic [7:0] stick;
  } tail_t;

  function automatic logic is_joy_key(input logic [7:0] k);
    return k == K_UP || k == K_DOWN || k == K_LEFT || k == K_RIGHT || k == K_SPACE;
  endfunction

  function automatic logic [7:0] c64_pos(input logic [7:0] k);
    logic [7:0] p;
    p = NOPOS;
    if (k >= 8'h04 && k <= 8'h1D) begin
      p = C64_LETTERS[5'(k - 8'h04)];
    end else if (k >= 8'h1E && k <= 8'h27) begin
      p = C64_DIGITS[4'(k - 8'h1E)];
    end else begin
      case (k)
        K_ENTER, K_KPENTER: p = 8'd8;
        K_BKSP, K_DEL: p = 8'd0;
        K_SPACE: p = 8'd39;
        8'h2D: p = 8'd29;
        8'h2E: p = 8'd46;
        8'h33: p = 8'd22;
        8'h34: p = 8'd45;
        8'h35: p = 8'd15;
        8'h36: p = 8'd61;
        8'h37: p = 8'd37;
        8'h38: p = 8'd62;
        8'h2F: p = 8'd53;
        8'h30: p = 8'd14;
        8'h31: p = 8'd5;
        K_ESC: p = 8'd63;
        K_RIGHT, K_LEFT: p = 8'd16;
        K_DOWN, K_UP: p = 8'd56;
        default: p = NOPOS;
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] msx_pos(input logic [7:0] k);
    logic [7:0] p;
    p = NOPOS;
    if (k >= 8'h04 && k <= 8'h1D) begin
      p = k + 8'd18;
    end else if (k >= 8'h1E && k <= 8'h26) begin
      p = k - 8'd29;
    end else begin
      case (k)
        8'h27: p = 8'd0;
        8'h2D: p = 8'd10;
        8'h2E: p = 8'd11;
        8'h31: p = 8'd12;
        8'h2F: p = 8'd13;
        8'h30: p = 8'd14;
        8'h33: p = 8'd15;
        8'h34: p = 8'd16;
        8'h35: p = 8'd17;
        8'h36: p = 8'd18;
        8'h37: p = 8'd19;
        8'h38: p = 8'd20;
        K_ENTER, K_KPENTER: p = 8'd63;
        K_BKSP: p = 8'd61;
        K_DEL: p = 8'd67;
        K_SPACE: p = 8'd64;
        K_ESC: p = 8'd58;
        K_TAB: p = 8'd59;
        K_LEFT: p = 8'd68;
        K_UP: p = 8'd69;
        K_DOWN: p = 8'd70;
        K_RIGHT: p = 8'd71;
        8'h3A: p = 8'd53;
        8'h3B: p = 8'd54;
        8'h3C: p = 8'd55;
        8'h3D: p = 8'd56;
        8'h3E: p = 8'd57;
        default: p = NOPOS;
      endcase
    end
    return p;
  endfunction

  function automatic logic [7:0] nes_mask(input logic [7:0] k);
    logic [7:0] m;
    case (k)
      K_UP: m = 8'h10;
      K_DOWN: m = 8'h20;
      K_LEFT: m = 8'h40;
      K_RIGHT: m = 8'h80;
      K_X: m = 8'h01;
      K_Z: m = 8'h02;
      K_TAB: m = 8'h04;
      K_ENTER: m = 8'h08;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  // {hit, switches[2:0], direction[3:0]}
  function automatic logic [7:0] atari_map(input logic [7:0] k);
    logic [7:0] m;
    case (k)
      K_UP: m = 8'h81;
      K_DOWN: m = 8'h82;
      K_LEFT: m = 8'h84;
      K_RIGHT: m = 8'h88;
      K_SPACE, K_X: m = 8'h90;
      K_TAB: m = 8'hA0;
      K_ENTER: m = 8'hC0;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

/* sv/hid_report_to_console_keys_core.sv */
// top level: hid boot keyboard report to console key and pad events
// depends on hrck_pkg, hrck_lane and hrck_merge
`default_nettype none
// Each request is one boot keyboard report. At acceptance twelve lanes diff
// it against the previous report at once (six key-down lanes, six key-up
// lanes) and the merging stage then issues one event per cycle, while out_ready
// does not stall the output, into an output register. A report makes 0 to 16
// events, 16 at most, capped by MAX_EVENTS in the merging stage.
// The next report is accepted in the cycle the last event of the current one
// is issued, so there is no gap between reports. A report that makes no
// events leaves the block free for the next report. The user writes platform
// and joystick mode on the cfg port only while the block is idle; the block does not enforce this.
module hid_report_to_console_keys_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [2:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire hrck_pkg::in_req_t   in_req,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output hrck_pkg::out_res_t       out_res
);

  logic [2:0] platform;
  logic       joystick_mode;
  logic [7:0] previous_keys [hrck_pkg::KEY_SLOTS];
  logic [7:0] keys [hrck_pkg::KEY_SLOTS];
  logic [7:0] lane_codes [hrck_pkg::LANES];
  logic [hrck_pkg::LANES-1:0] hits;
  logic [hrck_pkg::TAIL-1:0]  tail_mask;
  hrck_pkg::tail_t tail;
  logic       accept;
  logic       h_up, h_down, h_left, h_right, h_space, h_z, h_x;
  logic       is_sms;
  logic [7:0] stick;

  assign keys[0] = in_req.key_slot_0;
  assign keys[1] = in_req.key_slot_1;
  assign keys[2] = in_req.key_slot_2;
  assign keys[3] = in_req.key_slot_3;
  assign keys[4] = in_req.key_slot_4;
  assign keys[5] = in_req.key_slot_5;

  assign accept = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      platform      <= hrck_pkg::PLAT_C64;
      joystick_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        hrck_pkg::CFG_PLATFORM: platform <= cfg_data;
        hrck_pkg::CFG_JOYSTICK: joystick_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // previous report is replaced on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hrck_pkg::KEY_SLOTS; i++) previous_keys[i] <= '0;
    end else if (accept) begin
      previous_keys <= keys;
    end
  end

  // key-down lanes look at the new codes, key-up lanes at the old ones
  for (genvar g = 0; g < hrck_pkg::KEY_SLOTS; g++) begin : g_lanes
    assign lane_codes[g] = keys[g];
    assign lane_codes[hrck_pkg::KEY_SLOTS + g] = previous_keys[g];

    hrck_lane u_down (
      .code          (keys[g]),
      .other         (previous_keys),
      .platform      (platform),
      .joystick_mode (joystick_mode),
      .hit           (hits[g])
    );

    hrck_lane u_up (
      .code          (previous_keys[g]),
      .other         (keys),
      .platform      (platform),
      .joystick_mode (joystick_mode),
      .hit           (hits[hrck_pkg::KEY_SLOTS + g])
    );
  end

  // which held keys the stick byte and the c64 shift line care about
  always_comb begin
    h_up = 1'b0; h_down = 1'b0; h_left = 1'b0; h_right = 1'b0;
    h_space = 1'b0; h_z = 1'b0; h_x = 1'b0;
    for (int i = 0; i < hrck_pkg::KEY_SLOTS; i++) begin
      if (keys[i] == hrck_pkg::K_UP) h_up = 1'b1;
      if (keys[i] == hrck_pkg::K_DOWN) h_down = 1'b1;
      if (keys[i] == hrck_pkg::K_LEFT) h_left = 1'b1;
      if (keys[i] == hrck_pkg::K_RIGHT) h_right = 1'b1;
      if (keys[i] == hrck_pkg::K_SPACE) h_space = 1'b1;
      if (keys[i] == hrck_pkg::K_Z) h_z = 1'b1;
      if (keys[i] == hrck_pkg::K_X) h_x = 1'b1;
    end
  end

  assign is_sms = platform == hrck_pkg::PLAT_SMS;

  // active-low pad byte, bits 4 and 5 gain extra keys on the sms
  assign stick = ~{2'b00, is_sms && h_x, h_space || (is_sms && h_z),
                   h_right, h_left, h_down, h_up};

  always_comb begin
    tail.shift = (in_req.modifier_byte & 8'h22) != 8'h00 ||
                 (platform == hrck_pkg::PLAT_C64 && !joystick_mode && (h_left || h_up));
    tail.ctrl  = (in_req.modifier_byte & 8'h11) != 8'h00;
    tail.alt   = (in_req.modifier_byte & 8'hCC) != 8'h00;
    tail.stick = (is_sms || joystick_mode) ? stick : 8'hFF;
    case (platform)
      hrck_pkg::PLAT_C64, hrck_pkg::PLAT_MSX: tail_mask = 4'b1111;
      hrck_pkg::PLAT_SMS: tail_mask = 4'b1000;
      default: tail_mask = 4'b0000;
    endcase
  end

  hrck_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .load_mask  ({tail_mask, hits}),
    .load_codes (lane_codes),
    .load_tail  (tail),
    .platform   (platform),
    .free       (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

endmodule
`default_nettype wire

/* sv/hrck_lane.sv */
// one diff lane: is this slot's code absent from the other report, and does it make an event
// depends on hrck_pkg
`default_nettype none
module hrck_lane (
  input  wire logic [7:0] code,
  input  wire logic [7:0] other [hrck_pkg::KEY_SLOTS],
  input  wire logic [2:0] platform,
  input  wire logic       joystick_mode,
  output logic            hit
);

  logic found;
  logic counts;
  logic [7:0] amap;

  assign amap = hrck_pkg::atari_map(code);

  always_comb begin
    found = 1'b0;
    for (int i = 0; i < hrck_pkg::KEY_SLOTS; i++) begin
      if (other[i] == code) found = 1'b1;
    end
  end

  always_comb begin
    case (platform)
      hrck_pkg::PLAT_C64:
        counts = !(joystick_mode && hrck_pkg::is_joy_key(code)) &&
                 hrck_pkg::c64_pos(code) != hrck_pkg::NOPOS;
      hrck_pkg::PLAT_MSX:
        counts = !(joystick_mode && hrck_pkg::is_joy_key(code)) &&
                 hrck_pkg::msx_pos(code) != hrck_pkg::NOPOS;
      hrck_pkg::PLAT_NES: counts = 1'b1;
      hrck_pkg::PLAT_ATARI: counts = amap[7];
      default: counts = 1'b0;
    endcase
  end

  assign hit = code != 8'h00 && !found && counts;

endmodule
`default_nettype wire

/* sv/hrck_merge.sv */
// merging stage: walks the pending event mask one event per cycle, unless out_ready stalls it, into an output register
// depends on hrck_pkg; holds the nes and atari button state
`default_nettype none
module hrck_merge (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      load,
  input  wire logic [hrck_pkg::NPEND-1:0] load_mask,
  input  wire logic [7:0]                load_codes [hrck_pkg::LANES],
  input  wire hrck_pkg::tail_t           load_tail,
  input  wire logic [2:0]                platform,
  output logic                           free,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output hrck_pkg::out_res_t             out_res
);

  logic [hrck_pkg::NPEND-1:0]  pend;
  logic [hrck_pkg::CNT_W-1:0]  count;
  logic [7:0]                  codes [hrck_pkg::LANES];
  hrck_pkg::tail_t             tail;
  logic [7:0]                  nes_buttons;
  logic [3:0]                  atari_direction;
  logic [2:0]                  atari_switches;

  logic [hrck_pkg::PICK_W-1:0] pick;
  logic [hrck_pkg::NPEND-1:0]  rest;
  logic                        emit;
  logic                        last;
  logic [7:0]                  code;
  logic                        down;
  logic [7:0]                  pos;
  logic [7:0]                  amap;
  logic [7:0]                  nes_next;
  logic [3:0]                  dir_next;
  logic [2:0]                  sw_next;
  logic [1:0]                  tidx;
  hrck_pkg::out_res_t          res;

  always_comb begin
    pick = '0;
    for (int i = hrck_pkg::NPEND - 1; i >= 0; i--) begin
      if (pend[i]) pick = hrck_pkg::PICK_W'(i);
    end
  end

  assign rest = pend & ~(hrck_pkg::NPEND'(1) << pick);
  assign emit = (|pend) && (!out_valid || out_ready);
  assign last = rest == '0 || count == hrck_pkg::CNT_W'(hrck_pkg::MAX_EVENTS - 1);
  assign free = !(|pend) || (emit && last);

  assign code = codes[pick[hrck_pkg::LANE_W-1:0]];
  assign down = pick < hrck_pkg::PICK_W'(hrck_pkg::KEY_SLOTS);
  assign pos  = (platform == hrck_pkg::PLAT_C64) ? hrck_pkg::c64_pos(code)
                                                 : hrck_pkg::msx_pos(code);
  assign amap = hrck_pkg::atari_map(code);
  assign nes_next = down ? (nes_buttons | hrck_pkg::nes_mask(code))
                         : (nes_buttons & ~hrck_pkg::nes_mask(code));
  assign dir_next = down ? (atari_direction | amap[3:0]) : (atari_direction & ~amap[3:0]);
  assign sw_next  = down ? (atari_switches | amap[6:4]) : (atari_switches & ~amap[6:4]);
  assign tidx = 2'(pick - hrck_pkg::PICK_W'(hrck_pkg::LANES));

  always_comb begin
    res = '0;
    res.last_event = last;
    if (pick < hrck_pkg::PICK_W'(hrck_pkg::LANES)) begin
      case (platform)
        hrck_pkg::PLAT_C64, hrck_pkg::PLAT_MSX: begin
          res.event_kind = hrck_pkg::KIND_LINE;
          res.matrix_row = pos[6:3];
          res.matrix_col = pos[2:0];
          res.pressed    = down;
        end
        hrck_pkg::PLAT_NES: begin
          res.event_kind = hrck_pkg::KIND_PAD;
          res.pad_byte   = nes_next;
        end
        default: begin
          res.event_kind = hrck_pkg::KIND_PAD;
          res.pad_byte   = {1'b0, sw_next, dir_next};
        end
      endcase
    end else begin
      case (tidx)
        2'd0: begin
          res.matrix_row = (platform == hrck_pkg::PLAT_C64) ? 4'd7 : 4'd6;
          res.matrix_col = (platform == hrck_pkg::PLAT_C64) ? 3'd1 : 3'd0;
          res.pressed    = tail.shift;
        end
        2'd1: begin
          res.matrix_row = (platform == hrck_pkg::PLAT_C64) ? 4'd2 : 4'd6;
          res.matrix_col = (platform == hrck_pkg::PLAT_C64) ? 3'd7 : 3'd1;
          res.pressed    = tail.ctrl;
        end
        2'd2: begin
          res.matrix_row = (platform == hrck_pkg::PLAT_C64) ? 4'd5 : 4'd6;
          res.matrix_col = (platform == hrck_pkg::PLAT_C64) ? 3'd7 : 3'd2;
          res.pressed    = tail.alt;
        end
        default: begin
          res.event_kind = hrck_pkg::KIND_PAD;
          res.pad_byte   = tail.stick;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend            <= '0;
      count           <= '0;
      out_valid       <= 1'b0;
      nes_buttons     <= '0;
      atari_direction <= '0;
      atari_switches  <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        out_res   <= res;
        if (pick < hrck_pkg::PICK_W'(hrck_pkg::LANES)) begin
          if (platform == hrck_pkg::PLAT_NES) nes_buttons <= nes_next;
          if (platform == hrck_pkg::PLAT_ATARI) begin
            atari_direction <= dir_next;
            atari_switches  <= sw_next;
          end
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        pend  <= load_mask;
        count <= '0;
        codes <= load_codes;
        tail  <= load_tail;
      end else if (emit) begin
        count <= count + 1'b1;
        pend  <= last ? '0 : rest;
      end
    end
  end

endmodule
`default_nettype wire

/* bench/tb_hid_report_to_console_keys_core.sv */
// testbench for the hid report to console keys block: directed and random reports
// depends on hrck_pkg and hid_report_to_console_keys_core
`timescale 1ns / 1ps
module tb_hid_report_to_console_keys_core;
  import hrck_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [2:0] cfg_data = 3'd0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_res_t out_res;

  always #2 clk = ~clk;

  hid_report_to_console_keys_core dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
    .out_valid(out_valid), .out_ready(out_ready), .out_res(out_res)
  );

  // predictor state, mirrors the block
  logic [2:0] sh_platform;
  logic sh_joy;
  logic [7:0] sh_prev [KEY_SLOTS];
  logic [7:0] sh_nes;
  logic [3:0] sh_adir;
  logic [2:0] sh_asw;

  out_res_t event_queue [$];
  int errors = 0;
  int reports_sent = 0;
  int events_seen = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;   // no idling in the last part

  // ---------------- predictor ----------------
  function automatic bit holds8(logic [7:0] s [KEY_SLOTS], logic [7:0] k);
    for (int i = 0; i < KEY_SLOTS; i++) if (s[i] == k) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] c64_spot(logic [7:0] k);
    logic [7:0] lt [26];
    logic [7:0] dg [10];
    lt = '{8'd17, 8'd35, 8'd34, 8'd18, 8'd49, 8'd42, 8'd19, 8'd43, 8'd12, 8'd20, 8'd44,
           8'd21, 8'd36, 8'd60, 8'd52, 8'd13, 8'd55, 8'd10, 8'd41, 8'd50, 8'd51, 8'd59,
           8'd9, 8'd58, 8'd11, 8'd33};
    dg = '{8'd7, 8'd31, 8'd1, 8'd25, 8'd2, 8'd26, 8'd3, 8'd27, 8'd4, 8'd28};
    if (k >= 8'h04 && k <= 8'h1D) return lt[5'(k - 8'h04)];
    if (k >= 8'h1E && k <= 8'h27) return dg[4'(k - 8'h1E)];
    case (k)
      K_ENTER, K_KPENTER: return 8'd8;
      K_BKSP, K_DEL: return 8'd0;
      K_SPACE: return 8'd39;
      8'h2D: return 8'd29;
      8'h2E: return 8'd46;
      8'h33: return 8'd22;
      8'h34: return 8'd45;
      8'h35: return 8'd15;
      8'h36: return 8'd61;
      8'h37: return 8'd37;
      8'h38: return 8'd62;
      8'h2F: return 8'd53;
      8'h30: return 8'd14;
      8'h31: return 8'd5;
      K_ESC: return 8'd63;
      K_RIGHT, K_LEFT: return 8'd16;
      K_DOWN, K_UP: return 8'd56;
      default: return NOPOS;
    endcase
  endfunction

  // running order: position n gives row n/8 col n%8
  function automatic logic [7:0] msx_spot(logic [7:0] k);
    if (k >= 8'h04 && k <= 8'h1D) return k - 8'h04 + 8'd22;
    if (k >= 8'h1E && k <= 8'h26) return k - 8'h1E + 8'd1;
    case (k)
      8'h27: return 8'd0;
      8'h2D: return 8'd10;
      8'h2E: return 8'd11;
      8'h31: return 8'd12;
      8'h2F: return 8'd13;
      8'h30: return 8'd14;
      8'h33: return 8'd15;
      8'h34: return 8'd16;
      8'h35: return 8'd17;
      8'h36: return 8'd18;
      8'h37: return 8'd19;
      8'h38: return 8'd20;
      K_ENTER, K_KPENTER: return 8'd63;
      K_BKSP: return 8'd61;
      K_DEL: return 8'd67;
      K_SPACE: return 8'd64;
      K_ESC: return 8'd58;
      K_TAB: return 8'd59;
      K_LEFT: return 8'd68;
      K_UP: return 8'd69;
      K_DOWN: return 8'd70;
      K_RIGHT: return 8'd71;
      8'h3A: return 8'd53;
      8'h3B: return 8'd54;
      8'h3C: return 8'd55;
      8'h3D: return 8'd56;
      8'h3E: return 8'd57;
      default: return NOPOS;
    endcase
  endfunction

  function automatic logic [7:0] nes_bit(logic [7:0] k);
    case (k)
      K_UP: return 8'h10;
      K_DOWN: return 8'h20;
      K_LEFT: return 8'h40;
      K_RIGHT: return 8'h80;
      K_X: return 8'h01;
      K_Z: return 8'h02;
      K_TAB: return 8'h04;
      K_ENTER: return 8'h08;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] stick_of(logic [7:0] s [KEY_SLOTS], bit sms);
    logic [7:0] m;
    m = 8'hFF;
    if (holds8(s, K_UP)) m[0] = 1'b0;
    if (holds8(s, K_DOWN)) m[1] = 1'b0;
    if (holds8(s, K_LEFT)) m[2] = 1'b0;
    if (holds8(s, K_RIGHT)) m[3] = 1'b0;
    if (holds8(s, K_SPACE) || (sms && holds8(s, K_Z))) m[4] = 1'b0;
    if (sms && holds8(s, K_X)) m[5] = 1'b0;
    return m;
  endfunction

  task automatic push_event(ref out_res_t evs [$], input logic kind, input logic [3:0] row,
                            input logic [2:0] col, input logic prs, input logic [7:0] pad);
    out_res_t e;
    if (evs.size() >= MAX_EVENTS) return;
    e.event_kind = kind;
    e.matrix_row = row;
    e.matrix_col = col;
    e.pressed = prs;
    e.pad_byte = pad;
    e.last_event = 1'b0;
    evs.push_back(e);
  endtask

  task automatic key_change(ref out_res_t evs [$], input logic [7:0] k, input bit down);
    logic [7:0] p, d, s;
    case (sh_platform)
      PLAT_C64, PLAT_MSX: begin
        if (sh_joy && (k == K_UP || k == K_DOWN || k == K_LEFT || k == K_RIGHT ||
                       k == K_SPACE)) return;
        p = (sh_platform == PLAT_C64) ? c64_spot(k) : msx_spot(k);
        if (p != NOPOS) push_event(evs, KIND_LINE, p[6:3], p[2:0], down, 8'h00);
      end
      PLAT_NES: begin
        if (down) sh_nes = sh_nes | nes_bit(k);
        else sh_nes = sh_nes & ~nes_bit(k);
        push_event(evs, KIND_PAD, 4'd0, 3'd0, 1'b0, sh_nes);
      end
      PLAT_ATARI: begin
        d = 8'h00;
        s = 8'h00;
        case (k)
          K_UP: d = 8'h01;
          K_DOWN: d = 8'h02;
          K_LEFT: d = 8'h04;
          K_RIGHT: d = 8'h08;
          K_SPACE, K_X: s = 8'h01;
          K_TAB: s = 8'h02;
          K_ENTER: s = 8'h04;
          default: return;
        endcase
        if (down) begin
          sh_adir = sh_adir | d[3:0];
          sh_asw = sh_asw | s[2:0];
        end else begin
          sh_adir = sh_adir & ~d[3:0];
          sh_asw = sh_asw & ~s[2:0];
        end
        push_event(evs, KIND_PAD, 4'd0, 3'd0, 1'b0, {1'b0, sh_asw, sh_adir});
      end
      default: ;
    endcase
  endtask

  // works out the events one report causes and queues them
  task automatic predict_report(input in_req_t r);
    logic [7:0] keys [KEY_SLOTS];
    out_res_t evs [$];
    bit shf, ctl, alt;
    keys = '{r.key_slot_0, r.key_slot_1, r.key_slot_2, r.key_slot_3, r.key_slot_4,
             r.key_slot_5};
    shf = (r.modifier_byte & 8'h22) != 8'h00;
    ctl = (r.modifier_byte & 8'h11) != 8'h00;
    alt = (r.modifier_byte & 8'hCC) != 8'h00;
    for (int i = 0; i < KEY_SLOTS; i++)
      if (keys[i] != 8'h00 && !holds8(sh_prev, keys[i])) key_change(evs, keys[i], 1'b1);
    for (int i = 0; i < KEY_SLOTS; i++)
      if (sh_prev[i] != 8'h00 && !holds8(keys, sh_prev[i]))
        key_change(evs, sh_prev[i], 1'b0);
    if (sh_platform == PLAT_C64) begin
      // cursor left and up also hold shift in typing mode
      if (!sh_joy) shf = shf || holds8(keys, K_LEFT) || holds8(keys, K_UP);
      push_event(evs, KIND_LINE, 4'd7, 3'd1, shf, 8'h00);
      push_event(evs, KIND_LINE, 4'd2, 3'd7, ctl, 8'h00);
      push_event(evs, KIND_LINE, 4'd5, 3'd7, alt, 8'h00);
      push_event(evs, KIND_PAD, 4'd0, 3'd0, 1'b0, sh_joy ? stick_of(keys, 1'b0) : 8'hFF);
    end else if (sh_platform == PLAT_MSX) begin
      push_event(evs, KIND_LINE, 4'd6, 3'd0, shf, 8'h00);
      push_event(evs, KIND_LINE, 4'd6, 3'd1, ctl, 8'h00);
      push_event(evs, KIND_LINE, 4'd6, 3'd2, alt, 8'h00);
      push_event(evs, KIND_PAD, 4'd0, 3'd0, 1'b0, sh_joy ? stick_of(keys, 1'b0) : 8'hFF);
    end else if (sh_platform == PLAT_SMS) begin
      push_event(evs, KIND_PAD, 4'd0, 3'd0, 1'b0, stick_of(keys, 1'b1));
    end
    sh_prev = keys;
    if (evs.size() > 0) evs[evs.size() - 1].last_event = 1'b1;
    foreach (evs[i]) event_queue.push_back(evs[i]);
  endtask

  // ---------------- stimulus helpers ----------------
  // valid drops only when a gap is taken or a config is written, so requests can follow back to back
  task automatic random_gap();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 12);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_report(input in_req_t r);
    random_gap();
    in_valid <= 1'b1;
    in_req <= r;
    predict_report(r);
    do @(posedge clk); while (!in_ready);
    reports_sent++;
  endtask

  task automatic send_keys(input logic [7:0] m, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
                           input logic [7:0] f);
    send_report({m, a, b, c, d, e, f});
  endtask

  // config writes only when idle; waits for queue to drain plus latency
  task automatic write_cfg(input logic idx, input logic [2:0] val);
    in_valid <= 1'b0;
    while (event_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_PLATFORM) sh_platform = val;
    else sh_joy = val[0];
  endtask

  task automatic set_mode(input logic [2:0] plat, input logic joy);
    write_cfg(CFG_PLATFORM, plat);
    write_cfg(CFG_JOYSTICK, joy);
  endtask

  function automatic logic [7:0] pick_key();
    logic [7:0] pool [16];
    pool = '{K_UP, K_DOWN, K_LEFT, K_RIGHT, K_SPACE, K_X, K_Z, K_TAB, K_ENTER, K_ESC,
             K_DEL, K_KPENTER, 8'h04, 8'h1E, 8'h3A, 8'h27};
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'($urandom_range(0, 255));
      default: return pool[4'($urandom_range(0, 15))];
    endcase
  endfunction

  // mostly small edits of the last report, so keys are held and released
  task automatic random_reports(input int count);
    in_req_t r;
    logic [7:0] cur [KEY_SLOTS];
    cur = sh_prev;
    repeat (count) begin
      for (int i = 0; i < KEY_SLOTS; i++)
        if ($urandom_range(0, 2) == 0) cur[i] = pick_key();
      r = {8'($urandom_range(0, 255)), cur[0], cur[1], cur[2], cur[3], cur[4], cur[5]};
      send_report(r);
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_c64_directed();
    set_mode(PLAT_C64, 1'b0);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_keys(8'hFF, 8'hFF, 8'h04, 8'h1D, 8'h1E, 8'h27, K_LEFT);
    send_keys(8'h22, K_UP, K_UP, K_ESC, K_ENTER, K_KPENTER, K_DEL);
    send_keys(8'h11, 8'h43, 8'h44, 8'h45, 8'h00, 8'h00, 8'h00);   // f10 to f12 are unmapped
    send_keys(8'hCC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    write_cfg(CFG_JOYSTICK, 1'b1);
    send_keys(8'h00, K_UP, K_DOWN, K_LEFT, K_RIGHT, K_SPACE, 8'h04);
    send_keys(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_msx_directed();
    set_mode(PLAT_MSX, 1'b0);
    send_keys(8'h02, K_TAB, K_BKSP, 8'h3E, 8'h38, 8'h27, K_RIGHT);
    send_keys(8'h40, 8'h1D, 8'h26, 8'h3A, K_SPACE, 8'h00, 8'h00);
    write_cfg(CFG_JOYSTICK, 1'b1);
    send_keys(8'h80, K_SPACE, K_LEFT, 8'h05, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_pads_directed();
    set_mode(PLAT_NES, 1'b0);
    send_keys(8'h00, K_X, K_Z, K_TAB, K_ENTER, K_UP, K_DOWN);
    send_keys(8'h00, K_LEFT, K_RIGHT, 8'h99, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    set_mode(PLAT_ATARI, 1'b1);
    send_keys(8'h00, K_UP, K_DOWN, K_LEFT, K_RIGHT, K_SPACE, K_X);
    send_keys(8'h00, K_TAB, K_ENTER, 8'h04, 8'h00, 8'h00, 8'h00);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    set_mode(PLAT_SMS, 1'b0);
    send_keys(8'h00, K_Z, K_X, K_UP, K_RIGHT, 8'h00, 8'h00);
    send_keys(8'h00, K_SPACE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    write_cfg(CFG_PLATFORM, 3'd7);   // unused code: nothing comes out
    send_keys(8'h00, 8'h04, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
    write_cfg(CFG_PLATFORM, 3'd5);
    send_keys(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random();
    for (int p = 0; p < 6; p++) begin
      set_mode(3'($urandom_range(0, 4)), 1'($urandom_range(0, 1)));
      if (p == 5) quiet = 1'b1;
      random_reports(16);
    end
    set_mode(3'd6, 1'b0);
    random_reports(3);
  endtask

  // ---------------- result side ----------------
  always @(posedge clk) begin
    if (!quiet && $urandom_range(0, 7) == 0) out_ready <= 1'b0;
    else if (quiet || $urandom_range(0, 2) != 0) out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    out_res_t want;
    if (!rst && out_valid && out_ready) begin
      events_seen++;
      if (event_queue.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual %h", $time, out_res);
        errors++;
      end else begin
        want = event_queue.pop_front();
        if (out_res !== want) begin
          $display("%0t: event mismatch, expected %h, actual %h", $time, want, out_res);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    sh_platform = PLAT_C64;
    sh_joy = 1'b0;
    sh_prev = '{default: 8'h00};
    sh_nes = 8'h00;
    sh_adir = 4'h0;
    sh_asw = 3'h0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_c64_directed();
    test_msx_directed();
    test_pads_directed();
    test_random();
    in_valid <= 1'b0;
    while (event_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d reports and %0d events on all five platforms, both modes",
             reports_sent, events_seen);
    if (errors == 0 && event_queue.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
